/* rtl/core/vpd_pkg.sv */
`timescale 1ns / 1ps

package vpd_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int MAX_PAGES    = 64;
    localparam int PN_W         = 52;
    localparam int OFF_W        = 12;
    localparam int WORD_IDX_W   = 9;
    localparam int SLOT_W       = 6;
    localparam int COUNT_W      = 7;
    localparam int PAGE_ADDR_W  = SLOT_W + WORD_IDX_W;
    localparam int PAGE_WORDS   = MAX_PAGES * (PAGE_BYTES / 8);
    localparam int EPOCH_W      = 32;
    localparam int LIMIT_W      = 7;
    localparam int CFG_DATA_W   = 32;

    localparam logic REQ_READ   = 1'b0;
    localparam logic REQ_COMMIT = 1'b1;

    localparam logic REG_START_EPOCH  = 1'b0;
    localparam logic REG_RECORD_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_STALE     = 3'd4,
        ST_ADVANCE   = 3'd5
    } status_code_t;

    typedef struct packed {
        logic         load;
        logic         pn_rd;
        logic         idx_inc;
        logic         hit_take;
        logic         create;
        logic         clr_step;
        logic         ver_take;
        logic         word_rd;
        logic         word_b;
        logic         word_wr;
        logic         word_take;
        logic         ver_wr;
        logic         set_res;
        status_code_t res_code;
        logic         emit;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic commit;
        logic scan_end;
        logic hit;
        logic can_create;
        logic clear_last;
        logic ver_match;
        logic can_advance;
        logic crosses;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/vpd_ram.sv */
`timescale 1ns / 1ps

module vpd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/vpd_dpath.sv */
`timescale 1ns / 1ps

module vpd_dpath import vpd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    output dp_status_t       sts,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_wdata,
    input  logic             s_req_type,
    input  logic [63:0]      s_page_address,
    input  logic [63:0]      s_base_version,
    input  logic [15:0]      s_byte_offset,
    input  logic [3:0]       s_byte_count,
    input  logic [63:0]      s_write_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_status,
    output logic [63:0]      m_page_version,
    output logic [63:0]      m_read_data
);

    logic                  req_type_reg;
    logic [PN_W-1:0]       pnum_reg;
    logic [63:0]           base_reg;
    logic [OFF_W-1:0]      off_reg;
    logic [3:0]            cnt_reg;
    logic [63:0]           wdata_reg;
    logic                  bad_reg;
    logic [COUNT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [EPOCH_W-1:0]    epoch_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [WORD_IDX_W-1:0] clr_reg;
    logic [63:0]           ver_reg;
    logic [63:0]           word_reg;
    status_code_t          res_code_reg;
    logic                  m_valid_reg;
    logic [2:0]            m_status_reg;
    logic [63:0]           m_ver_reg;
    logic [63:0]           m_data_reg;

    logic [PN_W-1:0]        pn_rdata;
    logic [63:0]            ver_rdata;
    logic [63:0]            page_rdata;
    logic                   ver_we;
    logic [SLOT_W-1:0]      ver_waddr;
    logic [63:0]            ver_wdata;
    logic [63:0]            new_ver;
    logic                   page_we;
    logic [PAGE_ADDR_W-1:0] page_waddr;
    logic [PAGE_ADDR_W-1:0] page_raddr;
    logic [63:0]            page_wdata;
    logic [WORD_IDX_W-1:0]  word_idx;
    logic [COUNT_W-1:0]     lim;
    logic                   in_bad;
    logic [16:0]            in_end;
    logic [15:0]            cnt_mask;
    logic [15:0]            byte_mask;
    logic [127:0]           bit_mask;
    logic [127:0]           data_sh;
    logic [63:0]            merged;

    assign in_end = {1'b0, s_byte_offset} + 17'(s_byte_count);

    always_comb begin
        if (s_page_address[OFF_W-1:0] != '0) begin
            in_bad = 1'b1;
        end else if (s_req_type == REQ_READ) begin
            in_bad = (s_byte_offset >= 16'(PAGE_BYTES));
        end else begin
            in_bad = (s_base_version == 64'd0) || (s_byte_count == 4'd0)
                || (s_byte_count > 4'd8) || (in_end > 17'(PAGE_BYTES));
        end
    end

    assign lim     = (limit_reg < 7'(MAX_PAGES)) ? limit_reg : 7'(MAX_PAGES);
    assign new_ver = {epoch_reg, 32'd1};

    assign cnt_mask  = (16'd1 << cnt_reg) - 16'd1;
    assign byte_mask = cnt_mask << off_reg[2:0];
    assign data_sh   = {64'd0, wdata_reg} << {off_reg[2:0], 3'b000};

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            bit_mask[i*8 +: 8] = {8{byte_mask[i]}};
        end
    end

    always_comb begin
        if (cmd.word_b) begin
            merged = (page_rdata & ~bit_mask[127:64]) | (data_sh[127:64] & bit_mask[127:64]);
        end else begin
            merged = (page_rdata & ~bit_mask[63:0]) | (data_sh[63:0] & bit_mask[63:0]);
        end
    end

    assign word_idx   = cmd.word_b ? (off_reg[OFF_W-1:3] + 9'd1) : off_reg[OFF_W-1:3];
    assign page_raddr = {slot_reg, word_idx};
    assign page_we    = cmd.clr_step | cmd.word_wr;
    assign page_waddr = cmd.clr_step ? {slot_reg, clr_reg} : {slot_reg, word_idx};
    assign page_wdata = cmd.clr_step ? 64'd0 : merged;

    assign ver_we    = cmd.create | cmd.ver_wr;
    assign ver_waddr = cmd.create ? count_reg[SLOT_W-1:0] : slot_reg;
    assign ver_wdata = cmd.create ? new_ver : ver_reg;

    vpd_ram #(.WIDTH(PN_W), .DEPTH(MAX_PAGES)) u_pn_ram (
        .aclk  (aclk),
        .we    (cmd.create),
        .waddr (count_reg[SLOT_W-1:0]),
        .wdata (pnum_reg),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (pn_rdata)
    );

    vpd_ram #(.WIDTH(64), .DEPTH(MAX_PAGES)) u_ver_ram (
        .aclk  (aclk),
        .we    (ver_we),
        .waddr (ver_waddr),
        .wdata (ver_wdata),
        .raddr (slot_reg),
        .rdata (ver_rdata)
    );

    vpd_ram #(.WIDTH(64), .DEPTH(PAGE_WORDS)) u_page_ram (
        .aclk  (aclk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    always_comb begin
        sts.bad         = bad_reg;
        sts.commit      = (req_type_reg == REQ_COMMIT);
        sts.scan_end    = (idx_reg == count_reg);
        sts.hit         = (pn_rdata == pnum_reg);
        sts.can_create  = (count_reg < lim);
        sts.clear_last  = (clr_reg == '1);
        sts.ver_match   = (ver_rdata == base_reg);
        sts.can_advance = (ver_rdata[63:32] == epoch_reg) && (ver_rdata[31:0] != 32'hffff_ffff);
        sts.crosses     = ({1'b0, off_reg[2:0]} + cnt_reg) > 4'd8;
        sts.out_free    = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg   <= 32'd1;
            limit_reg   <= 7'd64;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_START_EPOCH:  epoch_reg <= cfg_wdata[EPOCH_W-1:0];
                    REG_RECORD_LIMIT: limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.create) begin
                count_reg <= count_reg + 7'd1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= s_req_type;
            pnum_reg     <= s_page_address[63:OFF_W];
            base_reg     <= s_base_version;
            off_reg      <= s_byte_offset[OFF_W-1:0];
            cnt_reg      <= s_byte_count;
            wdata_reg    <= s_write_data;
            bad_reg      <= in_bad;
            idx_reg      <= '0;
            word_reg     <= 64'd0;
            ver_reg      <= 64'd0;
        end
        if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 7'd1;
        end
        if (cmd.hit_take) begin
            slot_reg <= idx_reg[SLOT_W-1:0];
        end
        if (cmd.create) begin
            slot_reg <= count_reg[SLOT_W-1:0];
            ver_reg  <= new_ver;
            clr_reg  <= '0;
        end
        if (cmd.clr_step) begin
            clr_reg <= clr_reg + 9'd1;
        end
        if (cmd.ver_take) begin
            if (req_type_reg == REQ_COMMIT) begin
                ver_reg <= {ver_rdata[63:32], ver_rdata[31:0] + 32'd1};
            end else begin
                ver_reg <= ver_rdata;
            end
        end
        if (cmd.word_take) begin
            word_reg <= page_rdata;
        end
        if (cmd.set_res) begin
            res_code_reg <= cmd.res_code;
            if (cmd.res_code != ST_OK) begin
                ver_reg  <= 64'd0;
                word_reg <= 64'd0;
            end
        end
        if (cmd.emit) begin
            m_status_reg <= res_code_reg;
            m_ver_reg    <= ver_reg;
            m_data_reg   <= word_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_page_version = m_ver_reg;
    assign m_read_data    = m_data_reg;

endmodule

/* rtl/core/vpd_ctrl.sv */
`timescale 1ns / 1ps

module vpd_ctrl import vpd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PN_RD,
        S_PN_CMP,
        S_VER_RD,
        S_VER_CHK,
        S_RD_WAIT,
        S_WA_WR,
        S_WB_RD,
        S_WB_WR,
        S_VER_WR,
        S_CLEAR,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.res_code = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.bad) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_INVALID;
                    state_next   = S_RESP;
                end else begin
                    state_next = S_PN_RD;
                end
            end
            S_PN_RD: begin
                if (!sts.scan_end) begin
                    cmd.pn_rd  = 1'b1;
                    state_next = S_PN_CMP;
                end else if (sts.commit) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_RESP;
                end else if (sts.can_create) begin
                    cmd.create = 1'b1;
                    state_next = S_CLEAR;
                end else begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_FULL;
                    state_next   = S_RESP;
                end
            end
            S_PN_CMP: begin
                if (sts.hit) begin
                    cmd.hit_take = 1'b1;
                    state_next   = S_VER_RD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_PN_RD;
                end
            end
            S_VER_RD: begin
                state_next = S_VER_CHK;
            end
            S_VER_CHK: begin
                if (!sts.commit) begin
                    cmd.ver_take = 1'b1;
                    cmd.word_rd  = 1'b1;
                    state_next   = S_RD_WAIT;
                end else if (!sts.ver_match) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_STALE;
                    state_next   = S_RESP;
                end else if (!sts.can_advance) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_ADVANCE;
                    state_next   = S_RESP;
                end else begin
                    cmd.ver_take = 1'b1;
                    cmd.word_rd  = 1'b1;
                    state_next   = S_WA_WR;
                end
            end
            S_RD_WAIT: begin
                cmd.word_take = 1'b1;
                cmd.set_res   = 1'b1;
                state_next    = S_RESP;
            end
            S_WA_WR: begin
                cmd.word_wr = 1'b1;
                state_next  = sts.crosses ? S_WB_RD : S_VER_WR;
            end
            S_WB_RD: begin
                cmd.word_rd = 1'b1;
                cmd.word_b  = 1'b1;
                state_next  = S_WB_WR;
            end
            S_WB_WR: begin
                cmd.word_wr = 1'b1;
                cmd.word_b  = 1'b1;
                state_next  = S_VER_WR;
            end
            S_VER_WR: begin
                cmd.ver_wr  = 1'b1;
                cmd.set_res = 1'b1;
                state_next  = S_RESP;
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clear_last) begin
                    cmd.set_res = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/versioned_page_directory.sv */
`timescale 1ns / 1ps

// Versioned page directory. Requests arrive on the s_ channel and each
// produces exactly one result on the m_ channel; both use valid/ready and a
// transfer happens when both are high. Registers start_epoch and
// record_limit are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while idle, as the block does not enforce this. One
// request is processed at a time. A rejected request goes from the check
// state straight to the response state. A lookup scans the stored page
// numbers in creation order, reading and comparing each record through the
// page-number memory. Creating a page clears its 512 words through the single
// write port of the page memory. A commit does one read-modify-write, or two
// when the bytes cross a word. The result sits in an output register; if the
// receiver stalls, the block holds it there and waits with the next result
// ready. The next request can be taken as soon as the result is in the output
// register. Reset empties the directory and sets start_epoch to 1 and
// record_limit to 64; no memory sweep follows reset.

module versioned_page_directory import vpd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [63:0] s_page_address,
    input  logic [63:0] s_base_version,
    input  logic [15:0] s_byte_offset,
    input  logic [3:0]  s_byte_count,
    input  logic [63:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_page_version,
    output logic [63:0] m_read_data
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    vpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vpd_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_req_type     (s_req_type),
        .s_page_address (s_page_address),
        .s_base_version (s_base_version),
        .s_byte_offset  (s_byte_offset),
        .s_byte_count   (s_byte_count),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_page_version (m_page_version),
        .m_read_data    (m_read_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while a request was in progress");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result produced without a request in progress");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_ADVANCE))
        else $error("undefined status code");

    a_ok_version: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> (m_page_version != 64'd0))
        else $error("successful result without a version");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_page_version == 64'd0 && m_read_data == 64'd0))
        else $error("failed result carries data");

endmodule

/* bench/vpd_checker.sv */
`timescale 1ns / 1ps

module vpd_checker import vpd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_req_type,
    input  logic [63:0] s_page_address,
    input  logic [63:0] s_base_version,
    input  logic [15:0] s_byte_offset,
    input  logic [3:0]  s_byte_count,
    input  logic [63:0] s_write_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [63:0] m_page_version,
    input  logic [63:0] m_read_data,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        status_code_t st;
        logic [63:0]  ver;
        logic [63:0]  data;
    } dir_result_t;

    localparam int WPP = PAGE_BYTES / 8;

    logic [31:0]  epoch;
    logic [6:0]   limit;
    int           used;
    logic [51:0]  pn_tab[MAX_PAGES];
    logic [63:0]  ver_tab[MAX_PAGES];
    logic [63:0]  words[PAGE_WORDS];
    dir_result_t  expected_results[$];

    function automatic int find_page(logic [51:0] pn);
        for (int i = 0; i < used; i++) begin
            if (pn_tab[i] == pn) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic predict_request(input logic rt, input logic [63:0] addr,
                                   input logic [63:0] base, input logic [15:0] off,
                                   input logic [3:0] cnt, input logic [63:0] wd);
        dir_result_t r;
        int slot;
        int lim;
        int o;
        r.st = ST_OK;
        r.ver = '0;
        r.data = '0;
        if (addr[11:0] != 0) begin
            r.st = ST_INVALID;
        end else if (rt == REQ_READ) begin
            if (off >= PAGE_BYTES) begin
                r.st = ST_INVALID;
            end else begin
                slot = find_page(addr[63:12]);
                lim = (limit < MAX_PAGES) ? limit : MAX_PAGES;
                if (slot < 0) begin
                    if (used >= lim) begin
                        r.st = ST_FULL;
                    end else begin
                        slot = used;
                        pn_tab[slot] = addr[63:12];
                        ver_tab[slot] = {epoch, 32'd1};
                        for (int w = 0; w < WPP; w++) begin
                            words[slot * WPP + w] = '0;
                        end
                        used++;
                    end
                end
                if (slot >= 0) begin
                    r.ver = ver_tab[slot];
                    r.data = words[slot * WPP + off[15:3]];
                end
            end
        end else begin
            if (base == 0 || cnt == 0 || cnt > 8 || int'(off) + int'(cnt) > PAGE_BYTES) begin
                r.st = ST_INVALID;
            end else begin
                slot = find_page(addr[63:12]);
                if (slot < 0) begin
                    r.st = ST_NOT_FOUND;
                end else if (ver_tab[slot] != base) begin
                    r.st = ST_STALE;
                end else if (ver_tab[slot][63:32] != epoch || ver_tab[slot][31:0] == '1) begin
                    r.st = ST_ADVANCE;
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        o = int'(off) + i;
                        words[slot * WPP + o / 8][(o % 8) * 8 +: 8] = wd[8 * i +: 8];
                    end
                    ver_tab[slot][31:0] = ver_tab[slot][31:0] + 1;
                    r.ver = ver_tab[slot];
                end
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge aclk) begin
        dir_result_t e;
        if (!aresetn) begin
            epoch <= 32'd1;
            limit <= 7'd64;
            used = 0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_START_EPOCH) begin
                    epoch <= cfg_wdata;
                end else begin
                    limit <= cfg_wdata[6:0];
                end
            end
            if (s_valid && s_ready) begin
                predict_request(s_req_type, s_page_address, s_base_version,
                                s_byte_offset, s_byte_count, s_write_data);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d", $time, m_status);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_status !== e.st || m_page_version !== e.ver
                            || m_read_data !== e.data) begin
                        $display("%0t: expected st=%0d ver=%h data=%h, got st=%0d ver=%h data=%h",
                                 $time, e.st, e.ver, e.data, m_status, m_page_version,
                                 m_read_data);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import vpd_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_req_type = 0;
    logic [63:0] s_page_address = '0;
    logic [63:0] s_base_version = '0;
    logic [15:0] s_byte_offset = '0;
    logic [3:0]  s_byte_count = '0;
    logic [63:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_status;
    logic [63:0] m_page_version;
    logic [63:0] m_read_data;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          stall_mode = 0;
    int          gap_max = 3;
    logic [63:0] known_pages[$];
    logic [63:0] seen_versions[$];

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    versioned_page_directory dut (.*);

    vpd_checker chk (.*);

    always @(posedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (m_valid && m_ready) begin
            seen_versions.push_back(m_page_version);
            if (seen_versions.size() > 32) begin
                void'(seen_versions.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else if (++idle_cycles > 200000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(input logic rt, input logic [63:0] addr, input logic [63:0] base,
                        input logic [15:0] off, input logic [3:0] cnt,
                        input logic [63:0] wd);
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_page_address <= addr;
        s_base_version <= base;
        s_byte_offset <= off;
        s_byte_count <= cnt;
        s_write_data <= wd;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, gap_max) != 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_page();
        if (known_pages.size() == 0 || $urandom_range(0, 5) == 0) begin
            return (rand64() >> $urandom_range(0, 50)) << 12;
        end
        return known_pages[$urandom_range(0, known_pages.size() - 1)];
    endfunction

    task automatic random_item();
        logic [63:0] addr;
        logic [63:0] base;
        logic [15:0] off;
        logic [3:0]  cnt;
        int          k;
        addr = pick_page();
        k = $urandom_range(0, 19);
        if (k == 0) begin
            addr = rand64();
        end
        if (known_pages.size() < 48 && $urandom_range(0, 3) == 0) begin
            known_pages.push_back(addr);
        end
        off = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
        cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        if (seen_versions.size() != 0 && $urandom_range(0, 4) != 0) begin
            base = seen_versions[$urandom_range(0, seen_versions.size() - 1)];
        end else begin
            base = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
        end
        send(1'($urandom_range(0, 1)), addr, base, off, cnt, rand64());
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(REQ_READ, 64'h0, 0, 0, 0, 0);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0001, 16'd4088, 4'd8, 64'hffff_ffff_ffff_ffff);
        send(REQ_READ, 64'h0, 0, 16'd4095, 0, 0);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0002, 16'd4093, 4'd3, 64'h0123_4567_89ab_cdef);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0003, 16'd4094, 4'd3, 64'h5);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0003, 16'd5, 4'd0, 64'h5);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0003, 16'd5, 4'd9, 64'h5);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0003, 16'd5, 4'd15, 64'h5);
        send(REQ_COMMIT, 64'h0, 64'd0, 16'd5, 4'd2, 64'h5);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0001, 16'd5, 4'd2, 64'h5);
        send(REQ_COMMIT, 64'hffff_ffff_ffff_f000, 64'h1, 16'd0, 4'd1, 64'h5);
        send(REQ_READ, 64'hffff_ffff_ffff_f000, 0, 16'hffff, 0, 0);
        send(REQ_READ, 64'h0000_0000_0000_0800, 0, 0, 0, 0);
        send(REQ_READ, 64'hffff_ffff_ffff_f000, 0, 16'd8, 0, 0);
        send(REQ_READ, 64'h0, 0, 16'd4088, 0, 0);
        drain();

        write_reg(REG_START_EPOCH, 32'hffff_ffff);
        write_reg(REG_RECORD_LIMIT, 32'd2);
        send(REQ_COMMIT, 64'h0, 64'h1_0000_0004, 16'd0, 4'd1, 64'h7);
        send(REQ_READ, 64'h5000, 0, 0, 0, 0);
        send(REQ_READ, 64'h0, 0, 0, 0, 0);
        drain();
        write_reg(REG_START_EPOCH, 32'd0);
        write_reg(REG_RECORD_LIMIT, 32'd0);
        send(REQ_READ, 64'h6000, 0, 0, 0, 0);
        drain();
        write_reg(REG_RECORD_LIMIT, 32'd127);
        send(REQ_READ, 64'h6000, 0, 0, 0, 0);
        send(REQ_COMMIT, 64'h6000, 64'h1, 16'd0, 4'd8, 64'hdead_beef_cafe_f00d);
        drain();
        write_reg(REG_START_EPOCH, 32'd1);
        write_reg(REG_RECORD_LIMIT, 32'd64);
        known_pages.push_back(64'h0);
        known_pages.push_back(64'h6000);
        known_pages.push_back(64'hffff_ffff_ffff_f000);

        for (int ph = 0; ph < 6; ph++) begin
            stall_mode = ph % 3;
            gap_max = (ph == 2) ? 0 : 3;
            for (int n = 0; n < 115; n++) begin
                random_item();
            end
            drain();
            case (ph)
                0: write_reg(REG_START_EPOCH, $urandom);
                1: write_reg(REG_RECORD_LIMIT, 32'd1);
                2: write_reg(REG_RECORD_LIMIT, 32'd64);
                3: write_reg(REG_START_EPOCH, 32'd1);
                default: write_reg(REG_START_EPOCH, 32'hffff_ffff);
            endcase
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
